// File: src/snoise2d_pkg.sv
// Package: constants and helper functions for the 2D simplex noise pipeline.
package snoise2d_pkg;

  localparam int GRADIENT_COUNT_DEF = 128;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int WORK_BITS   = 24;
  localparam int OUT_SHIFT   = 8;
  localparam int GIDX_W      = 8;
  localparam int OUT_W       = 18;

  localparam logic signed [31:0] SEED_RESET = 32'sd3;
  localparam logic signed [63:0] SKEW_Q32   = 64'sd1572067139;
  localparam logic signed [23:0] UNSKEW_W   = -24'sd3545443;
  localparam logic signed [31:0] RSQ_W      = 32'sd11184811;
  localparam logic signed [27:0] ONE_W      = 28'sd16777216;

  localparam logic [63:0] PX_MUL  = 64'h5205402B9270C86F;
  localparam logic [63:0] PY_MUL  = 64'h598CD327003817B5;
  localparam logic [31:0] MIX_L   = 32'hEEC546F5;
  localparam logic [31:0] MIX_H   = 32'h53A3F72D;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

  typedef logic signed [2:0]  ofs_t;
  typedef logic signed [21:0] grad_t;

  // index mod 24 for an 8-bit index: reciprocal multiply, then one subtract
  function automatic logic [4:0] mod24(input logic [GIDX_W-1:0] v);
    logic [15:0] prod;
    logic [3:0]  q;
    logic [8:0]  qm;
    logic [8:0]  r;
    prod = 16'(v) * 16'd171;
    q    = prod[15:12];
    qm   = 9'(q) * 9'd24;
    r    = 9'(v) - qm;
    return r[4:0];
  endfunction

  function automatic grad_t grad_x(input logic [4:0] g);
    grad_t r;
    case (g)
      5'd0:  r = 22'sd457500;
      5'd1:  r = 22'sd1104503;
      5'd2:  r = 22'sd1104503;
      5'd3:  r = 22'sd457500;
      5'd4:  r = -22'sd457500;
      5'd5:  r = -22'sd1104503;
      5'd6:  r = -22'sd1104503;
      5'd7:  r = -22'sd457500;
      5'd8:  r = 22'sd156045;
      5'd9:  r = 22'sd727777;
      5'd10: r = 22'sd948458;
      5'd11: r = 22'sd1185278;
      5'd12: r = 22'sd1185278;
      5'd13: r = 22'sd948458;
      5'd14: r = 22'sd727777;
      5'd15: r = 22'sd156045;
      5'd16: r = -22'sd156045;
      5'd17: r = -22'sd727777;
      5'd18: r = -22'sd948458;
      5'd19: r = -22'sd1185278;
      5'd20: r = -22'sd1185278;
      5'd21: r = -22'sd948458;
      5'd22: r = -22'sd727777;
      5'd23: r = -22'sd156045;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic grad_t grad_y(input logic [4:0] g);
    grad_t r;
    case (g)
      5'd0:  r = 22'sd1104503;
      5'd1:  r = 22'sd457500;
      5'd2:  r = -22'sd457500;
      5'd3:  r = -22'sd1104503;
      5'd4:  r = -22'sd1104503;
      5'd5:  r = -22'sd457500;
      5'd6:  r = 22'sd457500;
      5'd7:  r = 22'sd1104503;
      5'd8:  r = 22'sd1185278;
      5'd9:  r = 22'sd948458;
      5'd10: r = 22'sd727777;
      5'd11: r = 22'sd156045;
      5'd12: r = -22'sd156045;
      5'd13: r = -22'sd727777;
      5'd14: r = -22'sd948458;
      5'd15: r = -22'sd1185278;
      5'd16: r = -22'sd1185278;
      5'd17: r = -22'sd948458;
      5'd18: r = -22'sd727777;
      5'd19: r = -22'sd156045;
      5'd20: r = 22'sd156045;
      5'd21: r = 22'sd727777;
      5'd22: r = 22'sd948458;
      5'd23: r = 22'sd1185278;
      default: r = '0;
    endcase
    return r;
  endfunction

  // lattice offset times a hash prime, modulo 2^64
  function automatic logic [63:0] prime_step(input ofs_t o, input logic [63:0] p);
    logic [63:0] r;
    case (o)
      3'b111:  r = 64'd0 - p;
      3'b001:  r = p;
      3'b010:  r = {p[62:0], 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

  // unskewed displacement of a lattice vertex, Q.24
  function automatic logic signed [27:0] vtx_off(input ofs_t ox, input ofs_t oy);
    logic signed [27:0] oxw;
    logic signed [27:0] sw;
    oxw = 28'(ox);
    sw  = 28'(ox) + 28'(oy);
    return (oxw <<< WORK_BITS) + sw * 28'(UNSKEW_W);
  endfunction

endpackage

// File: src/simplex_noise_2d.sv
// Top: fully pipelined OpenSimplex2S 2D noise, one sample per clock if unstalled.
//
// Input channel in_valid/in_ready carries a point in_x_coord, in_y_coord (signed,
// FRACTION_BITS fraction bits). Output channel out_valid/out_ready carries
// out_noise_value, signed Q1.16, saturated. A transaction completes when valid
// and ready are both high at a rising edge.
// cfg_wr_en writes cfg_wr_data into the seed at the next edge; write only while
// no transaction is in flight.
// Throughput: one transaction per cycle when out_ready is high; twelve register
// stages, each with its own valid bit, and every multiplier (skew, hash primes,
// hash mix, squares, falloff powers, gradient dot) sits alone between registers,
// but for the mod 24 reduction of stage 8, which feeds the gradient product.
// A stage loads when it is empty or the stage after it loads, so bubbles close
// up while the receiver stalls and in_ready stays high until every stage holds
// a transaction. Nothing is lost or repeated under stall.
// Reset (rst_n low, synchronous) empties the pipeline and sets the seed to 3.
module simplex_noise_2d
  import snoise2d_pkg::*;
#(
  parameter int GRADIENT_COUNT = GRADIENT_COUNT_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [31:0]      in_x_coord,
  input  logic signed [31:0]      in_y_coord,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_noise_value,
  input  logic                    cfg_wr_en,
  input  logic signed [31:0]      cfg_wr_data
);

  localparam int NS  = 12;
  localparam int GE  = $clog2(GRADIENT_COUNT);
  localparam int HSH = (65 - GE > 63) ? 63 : 65 - GE;
  localparam int XSH = 32 - FRACTION_BITS;
  localparam int NV  = 4;

  logic signed [31:0] noise_seed_r;
  logic [NS:1] v_r;
  logic [NS:1] adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_seed_r <= SEED_RESET;
    end else if (cfg_wr_en) begin
      noise_seed_r <= cfg_wr_data;
    end
  end

  always_comb begin
    adv[NS] = !v_r[NS] | out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = !v_r[k] | adv[k+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: skew product
  logic signed [31:0] x1_r, y1_r;
  logic signed [63:0] p1_r;
  logic signed [32:0] sxy1;
  logic signed [63:0] p1_nxt;

  always_comb begin
    sxy1   = 33'(in_x_coord) + 33'(in_y_coord);
    p1_nxt = 64'(sxy1) * SKEW_Q32;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      x1_r <= in_x_coord;
      y1_r <= in_y_coord;
      p1_r <= p1_nxt;
    end
  end

  // stage 2: skewed coordinates, cell and fraction
  logic signed [31:0] xsb2_r, ysb2_r;
  logic [23:0] xi2_r, yi2_r;
  logic signed [63:0] s2, xs2, ys2;

  always_comb begin
    s2  = p1_r >>> FRACTION_BITS;
    xs2 = (64'(x1_r) <<< XSH) + s2;
    ys2 = (64'(y1_r) <<< XSH) + s2;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      xsb2_r <= xs2[63:32];
      ysb2_r <= ys2[63:32];
      xi2_r  <= xs2[31:8];
      yi2_r  <= ys2[31:8];
    end
  end

  // stage 3: prime partial products, unskew product
  logic [63:0] pxl3_r, pyl3_r;
  logic [31:0] pxh3_r, pyh3_r;
  logic xneg3_r, yneg3_r;
  logic signed [48:0] tp3_r;
  logic [23:0] xi3_r, yi3_r;
  logic signed [25:0] sxy3;

  always_comb begin
    sxy3 = $signed({1'b0, 25'(xi2_r) + 25'(yi2_r)});
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      pxl3_r  <= 64'(xsb2_r[31:0]) * 64'(PX_MUL[31:0]);
      pyl3_r  <= 64'(ysb2_r[31:0]) * 64'(PY_MUL[31:0]);
      pxh3_r  <= xsb2_r[31:0] * PX_MUL[63:32];
      pyh3_r  <= ysb2_r[31:0] * PY_MUL[63:32];
      xneg3_r <= xsb2_r[31];
      yneg3_r <= ysb2_r[31];
      tp3_r   <= 49'(sxy3) * 49'(UNSKEW_W);
      xi3_r   <= xi2_r;
      yi3_r   <= yi2_r;
    end
  end

  // stage 4: lattice hashes, origin offsets, vertex choice
  logic [63:0] xp4_r, yp4_r;
  logic signed [25:0] dx04_r, dy04_r;
  ofs_t ox4_r [NV];
  ofs_t oy4_r [NV];
  logic [31:0] xph4, yph4;
  logic signed [23:0] t4;
  logic signed [27:0] sxi4, syi4, xm4;
  ofs_t ox4_nxt [NV];
  ofs_t oy4_nxt [NV];

  always_comb begin
    xph4 = pxl3_r[63:32] + pxh3_r + (xneg3_r ? 32'd0 - PX_MUL[31:0] : 32'd0);
    yph4 = pyl3_r[63:32] + pyh3_r + (yneg3_r ? 32'd0 - PY_MUL[31:0] : 32'd0);
    t4   = tp3_r[47:24];
    sxi4 = $signed({4'b0, xi3_r});
    syi4 = $signed({4'b0, yi3_r});
    xm4  = sxi4 - syi4;
    ox4_nxt[0] = 3'sd0;
    oy4_nxt[0] = 3'sd0;
    ox4_nxt[1] = 3'sd1;
    oy4_nxt[1] = 3'sd1;
    if (t4 < UNSKEW_W) begin
      ox4_nxt[2] = (sxi4 + xm4 > ONE_W) ? 3'sd2 : 3'sd0;
      oy4_nxt[2] = 3'sd1;
      ox4_nxt[3] = 3'sd1;
      oy4_nxt[3] = (syi4 - xm4 > ONE_W) ? 3'sd2 : 3'sd0;
    end else begin
      ox4_nxt[2] = (sxi4 + xm4 < 0) ? -3'sd1 : 3'sd1;
      oy4_nxt[2] = 3'sd0;
      ox4_nxt[3] = 3'sd0;
      oy4_nxt[3] = (syi4 < xm4) ? -3'sd1 : 3'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      xp4_r  <= {xph4, pxl3_r[31:0]};
      yp4_r  <= {yph4, pyl3_r[31:0]};
      dx04_r <= $signed({2'b0, xi3_r}) + 26'(t4);
      dy04_r <= $signed({2'b0, yi3_r}) + 26'(t4);
      for (int v = 0; v < NV; v++) begin
        ox4_r[v] <= ox4_nxt[v];
        oy4_r[v] <= oy4_nxt[v];
      end
    end
  end

  // stage 5: vertex displacements, seed mix
  logic signed [27:0] dx5_r [NV];
  logic signed [27:0] dy5_r [NV];
  logic [63:0] m5_r [NV];
  logic [63:0] seed64;

  assign seed64 = 64'(noise_seed_r);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int v = 0; v < NV; v++) begin
        dx5_r[v] <= 28'(dx04_r) - vtx_off(ox4_r[v], oy4_r[v]);
        dy5_r[v] <= 28'(dy04_r) - vtx_off(oy4_r[v], ox4_r[v]);
        m5_r[v]  <= seed64 ^ (xp4_r + prime_step(ox4_r[v], PX_MUL))
                           ^ (yp4_r + prime_step(oy4_r[v], PY_MUL));
      end
    end
  end

  // stage 6: squares and hash mix partial products
  logic signed [55:0] sqx6_r [NV];
  logic signed [55:0] sqy6_r [NV];
  logic [63:0] hll6_r [NV];
  logic [31:0] hlh6_r [NV];
  logic [31:0] hhl6_r [NV];
  logic signed [27:0] dx6_r [NV];
  logic signed [27:0] dy6_r [NV];

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int v = 0; v < NV; v++) begin
        sqx6_r[v] <= 56'(dx5_r[v]) * 56'(dx5_r[v]);
        sqy6_r[v] <= 56'(dy5_r[v]) * 56'(dy5_r[v]);
        hll6_r[v] <= 64'(m5_r[v][31:0]) * 64'(MIX_L);
        hlh6_r[v] <= m5_r[v][31:0] * MIX_H;
        hhl6_r[v] <= m5_r[v][63:32] * MIX_L;
        dx6_r[v]  <= dx5_r[v];
        dy6_r[v]  <= dy5_r[v];
      end
    end
  end

  // stage 7: falloff base, gradient index
  logic signed [31:0] a7_r [NV];
  logic [GIDX_W-1:0] gi7_r [NV];
  logic signed [27:0] dx7_r [NV];
  logic signed [27:0] dy7_r [NV];
  logic [63:0] h7 [NV];
  logic [63:0] hf7 [NV];

  always_comb begin
    for (int v = 0; v < NV; v++) begin
      h7[v]  = {hll6_r[v][63:32] + hlh6_r[v] + hhl6_r[v], hll6_r[v][31:0]};
      hf7[v] = h7[v] ^ 64'($signed(h7[v]) >>> HSH);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int v = 0; v < NV; v++) begin
        a7_r[v]  <= RSQ_W - $signed(sqx6_r[v][55:24]) - $signed(sqy6_r[v][55:24]);
        gi7_r[v] <= GIDX_W'(hf7[v][GE:1]);
        dx7_r[v] <= dx6_r[v];
        dy7_r[v] <= dy6_r[v];
      end
    end
  end

  // stage 8: a squared, gradient products
  logic signed [51:0] a2p8_r [NV];
  logic signed [49:0] px8_r [NV];
  logic signed [49:0] py8_r [NV];
  logic [NV-1:0] drop8_r;
  logic signed [25:0] a8 [NV];
  logic [4:0] g8 [NV];

  always_comb begin
    for (int v = 0; v < NV; v++) begin
      a8[v] = a7_r[v][25:0];
      g8[v] = mod24(gi7_r[v]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      for (int v = 0; v < NV; v++) begin
        a2p8_r[v]  <= 52'(a8[v]) * 52'(a8[v]);
        px8_r[v]   <= 50'(grad_x(g8[v])) * 50'(dx7_r[v]);
        py8_r[v]   <= 50'(grad_y(g8[v])) * 50'(dy7_r[v]);
        drop8_r[v] <= (v >= 2) && (a7_r[v] <= 0);
      end
    end
  end

  // stage 9: a to the fourth, dot product
  logic signed [53:0] a4p9_r [NV];
  logic signed [31:0] dot9_r [NV];
  logic [NV-1:0] drop9_r;
  logic signed [26:0] a2_9 [NV];
  logic signed [50:0] ds9 [NV];

  always_comb begin
    for (int v = 0; v < NV; v++) begin
      a2_9[v] = a2p8_r[v][50:24];
      ds9[v]  = 51'(px8_r[v]) + 51'(py8_r[v]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      for (int v = 0; v < NV; v++) begin
        a4p9_r[v] <= 54'(a2_9[v]) * 54'(a2_9[v]);
        dot9_r[v] <= ds9[v][47:16];
      end
      drop9_r <= drop8_r;
    end
  end

  // stage 10: contribution product
  logic signed [60:0] cp10_r [NV];
  logic [NV-1:0] drop10_r;
  logic signed [28:0] a4_10 [NV];

  always_comb begin
    for (int v = 0; v < NV; v++) begin
      a4_10[v] = a4p9_r[v][52:24];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      for (int v = 0; v < NV; v++) begin
        cp10_r[v] <= 61'(a4_10[v]) * 61'(dot9_r[v]);
      end
      drop10_r <= drop9_r;
    end
  end

  // stage 11: sum of contributions
  logic signed [39:0] sum11_r;
  logic signed [39:0] sum11_nxt;

  always_comb begin
    sum11_nxt = '0;
    for (int v = 0; v < NV; v++) begin
      if (!drop10_r[v]) begin
        sum11_nxt = sum11_nxt + 40'($signed(cp10_r[v][60:24]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      sum11_r <= sum11_nxt;
    end
  end

  // stage 12: rescale and saturate into the output register
  logic signed [OUT_W-1:0] out_r;
  logic signed [31:0] sh12;
  logic signed [OUT_W-1:0] out_nxt;

  always_comb begin
    sh12 = sum11_r[39:OUT_SHIFT];
    if (sh12 > 32'(OUT_MAX)) begin
      out_nxt = OUT_MAX;
    end else if (sh12 < 32'(OUT_MIN)) begin
      out_nxt = OUT_MIN;
    end else begin
      out_nxt = sh12[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      out_r <= out_nxt;
    end
  end

  assign out_noise_value = out_r;

endmodule
